[sv/wsm_pkg.sv]
// ----------------------------------------------------------------------------
// wsm_pkg: shared types and constants for the wildcard string matcher
// Character folding, configuration register indexes, request codes and the
// control and status bundles between the top level and the mask cells.
// ----------------------------------------------------------------------------
package wsm_pkg;

  localparam int unsigned MASK_LEN_DEFAULT = 64;
  localparam int unsigned CHAR_W           = 8;
  localparam int unsigned CFG_IDX_W        = 1;
  localparam int unsigned CFG_DATA_W       = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CASE     = 1'b1;

  localparam logic REQ_MASK = 1'b0;
  localparam logic REQ_TEST = 1'b1;

  localparam logic [CHAR_W-1:0] WILD_RESET  = 8'd42;
  localparam logic              CASE_RESET  = 1'b1;
  localparam logic [CHAR_W-1:0] CHAR_LC_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z   = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_NONE   = 8'd0;

  typedef struct packed {
    logic [CHAR_W-1:0] char_raw;
    logic [CHAR_W-1:0] char_cur;
    logic [CHAR_W-1:0] wild_cur;
    logic [CHAR_W-1:0] wild_nxt;
    logic              case_cur;
    logic              case_nxt;
    logic              clear;
    logic              append;
  } cell_ctrl_t;

  typedef struct packed {
    logic used_eff;
    logic wild_cur;
    logic wild_nxt;
    logic keep;
    logic shift;
    logic act;
  } cell_stat_t;

  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c,
                                             input logic              case_sens);
    logic [CHAR_W-1:0] r;
    r = c;
    if (!case_sens && (c inside {[CHAR_LC_A:CHAR_LC_Z]})) begin
      r = c - CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

[sv/wsm_closure.sv]
// ----------------------------------------------------------------------------
// wsm_closure: wildcard closure over the position flags
// Spreads each active flag forward across runs of wildcard positions, using
// the carry chain of one adder (wildcard = propagate, active wildcard = generate).
// ----------------------------------------------------------------------------
module wsm_closure #(
  parameter int unsigned WIDTH = wsm_pkg::MASK_LEN_DEFAULT + 1
) (
  input  logic [WIDTH-1:0] seed_i,
  input  logic [WIDTH-2:0] wild_i,
  output logic [WIDTH-1:0] closed_o
);

  logic [WIDTH-1:0] prop;
  logic [WIDTH-1:0] gen;
  logic [WIDTH-1:0] sum;
  logic [WIDTH-1:0] carry;

  assign prop     = {1'b0, wild_i};
  assign gen      = seed_i & prop;
  assign sum      = prop + gen;
  assign carry    = sum ^ prop ^ gen;
  assign closed_o = seed_i | carry;

endmodule

[sv/wsm_cell.sv]
// ----------------------------------------------------------------------------
// wsm_cell: one mask position of the matcher chain
// Holds one mask byte, its fill bit and the active flag of the position after
// it; compares against the test character and hands flags to its neighbor.
// ----------------------------------------------------------------------------
module wsm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wsm_pkg::cell_ctrl_t ctrl_i,
  input  logic                prev_used_i,
  input  logic                a_here_i,
  input  logic                act_d_i,
  output wsm_pkg::cell_stat_t stat_o
);

  logic [wsm_pkg::CHAR_W-1:0] mask_q;
  logic [wsm_pkg::CHAR_W-1:0] mask_d;
  logic                       used_q;
  logic                       used_d;
  logic                       act_q;
  logic                       used_eff;
  logic                       write_en;
  logic [wsm_pkg::CHAR_W-1:0] fold_cur;
  logic [wsm_pkg::CHAR_W-1:0] fold_nxt;
  logic                       wild_cur;

  assign used_eff = used_q & ~ctrl_i.clear;
  assign write_en = ctrl_i.append & prev_used_i & ~used_eff;
  assign used_d   = used_eff | write_en;
  assign mask_d   = write_en ? ctrl_i.char_raw : mask_q;

  assign fold_cur = wsm_pkg::fold(mask_q, ctrl_i.case_cur);
  assign fold_nxt = wsm_pkg::fold(mask_d, ctrl_i.case_nxt);
  assign wild_cur = used_q & (fold_cur == ctrl_i.wild_cur);

  assign stat_o.used_eff = used_eff;
  assign stat_o.wild_cur = wild_cur;
  assign stat_o.wild_nxt = used_d & (fold_nxt == ctrl_i.wild_nxt);
  assign stat_o.keep     = a_here_i & wild_cur;
  assign stat_o.shift    = a_here_i & used_q & ~wild_cur & (fold_cur == ctrl_i.char_cur);
  assign stat_o.act      = act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      act_q  <= 1'b0;
    end else begin
      used_q <= used_d;
      act_q  <= act_d_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
  end

endmodule

[sv/wildcard_string_match_core.sv]
// ----------------------------------------------------------------------------
// wildcard_string_match_core: anchored wildcard string matcher
// A chain of MASK_LEN cells holds the mask and one active flag per cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o): one request per character.
//   req_type_i = mask loads a mask character, test streams a test character;
//   last_i closes the mask or the test string. Character 0 adds nothing.
//   Output channel (out_valid_o / out_ready_i): one result per test string,
//   matched_o and mask_error_o, shown the cycle after the last test request.
//   Throughput: one request per cycle, mask or test, when in_ready_o is high.
//   Cycle time is set by the wildcard closure, one carry chain across MASK_LEN + 1
//   positions. Configuration (cfg_we_i, cfg_idx_i, cfg_data_i): index 0 wildcard
//   byte, index 1 case-sensitive compare; takes effect on the next request.
//   Reset: empty mask, no overflow, no result pending, wildcard '*', exact
//   compare; no clearing pass, the chain is ready right away.
//   Stall: a held result keeps in_ready_o equal to out_ready_i; requests that
//   give no result are taken once the result register frees up.
// ----------------------------------------------------------------------------
module wildcard_string_match_core #(
  parameter int unsigned MASK_LEN = wsm_pkg::MASK_LEN_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [wsm_pkg::CHAR_W-1:0]     char_value_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           matched_o,
  output logic                           mask_error_o,
  input  logic                           cfg_we_i,
  input  logic [wsm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wsm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NPOS = MASK_LEN + 1;

  logic [wsm_pkg::CHAR_W-1:0] wild_q;
  logic [wsm_pkg::CHAR_W-1:0] wild_d;
  logic                       case_q;
  logic                       case_d;
  logic                       loading_q;
  logic                       loading_d;
  logic                       started_q;
  logic                       started_d;
  logic                       ovf_q;
  logic                       ovf_d;
  logic                       a0_q;
  logic                       out_valid_q;
  logic                       out_valid_d;
  logic                       matched_q;
  logic                       matched_d;
  logic                       mask_err_q;

  logic                       accept;
  logic                       is_mask;
  logic                       is_test;
  logic                       has_char;
  logic                       take;
  logic                       res_load;
  logic                       empty;
  logic                       full;
  logic                       hit;

  wsm_pkg::cell_ctrl_t        ctrl;
  wsm_pkg::cell_stat_t        stat [MASK_LEN];

  logic [MASK_LEN-1:0]        used_v;
  logic [MASK_LEN-1:0]        wild_cur_v;
  logic [MASK_LEN-1:0]        wild_nxt_v;
  logic [MASK_LEN:0]          used_ext;
  logic [NPOS-1:0]            act_v;
  logic [NPOS-1:0]            f_step;
  logic [NPOS-1:0]            a_step;
  logic [NPOS-1:0]            a_new;
  logic [NPOS-1:0]            a_lead;
  logic [NPOS-1:0]            act_d;
  logic [NPOS-1:0]            end_v;
  logic [NPOS-1:0]            lead_seed;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;
  assign is_mask    = accept & (req_type_i == wsm_pkg::REQ_MASK);
  assign is_test    = accept & (req_type_i == wsm_pkg::REQ_TEST);
  assign has_char   = char_value_i != wsm_pkg::CHAR_NONE;
  assign take       = is_test & has_char;
  assign res_load   = is_test & last_i;

  assign wild_d = (cfg_we_i && (cfg_idx_i == wsm_pkg::REG_WILDCARD)) ?
                  cfg_data_i[wsm_pkg::CHAR_W-1:0] : wild_q;
  assign case_d = (cfg_we_i && (cfg_idx_i == wsm_pkg::REG_CASE)) ? cfg_data_i[0] : case_q;

  assign ctrl.char_raw = char_value_i;
  assign ctrl.char_cur = wsm_pkg::fold(char_value_i, case_q);
  assign ctrl.wild_cur = wsm_pkg::fold(wild_q, case_q);
  assign ctrl.wild_nxt = wsm_pkg::fold(wild_d, case_d);
  assign ctrl.case_cur = case_q;
  assign ctrl.case_nxt = case_d;
  assign ctrl.clear    = is_mask & ~loading_q;
  assign ctrl.append   = is_mask & has_char;

  assign used_ext = {used_v, 1'b1};

  for (genvar j = 0; j < MASK_LEN; j++) begin : g_cell
    wsm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_used_i (used_ext[j]),
      .a_here_i    (act_v[j]),
      .act_d_i     (act_d[j+1]),
      .stat_o      (stat[j])
    );
  end

  always_comb begin
    f_step   = '0;
    act_v    = '0;
    act_v[0] = a0_q;
    for (int j = 0; j < MASK_LEN; j++) begin
      used_v[j]     = stat[j].used_eff;
      wild_cur_v[j] = stat[j].wild_cur;
      wild_nxt_v[j] = stat[j].wild_nxt;
      act_v[j+1]    = stat[j].act;
      f_step[j]     = f_step[j] | stat[j].keep;
      f_step[j+1]   = stat[j].shift;
    end
  end

  assign lead_seed = NPOS'(1);

  wsm_closure #(.WIDTH(NPOS)) u_step_closure (
    .seed_i   (f_step),
    .wild_i   (wild_cur_v),
    .closed_o (a_step)
  );

  wsm_closure #(.WIDTH(NPOS)) u_lead_closure (
    .seed_i   (lead_seed),
    .wild_i   (wild_nxt_v),
    .closed_o (a_lead)
  );

  assign full  = used_v[MASK_LEN-1];
  assign empty = ~used_v[0];
  assign end_v = used_ext & ~{1'b0, used_v};
  assign a_new = take ? a_step : act_v;
  assign hit   = |(a_new & end_v);
  assign act_d = started_d ? a_new : a_lead;

  always_comb begin
    loading_d = loading_q;
    started_d = started_q;
    if (is_mask) begin
      loading_d = ~last_i;
      started_d = 1'b0;
    end else if (is_test) begin
      loading_d = 1'b0;
      started_d = ~last_i;
    end
  end

  assign ovf_d       = (ovf_q & ~ctrl.clear) | (ctrl.append & full);
  assign out_valid_d = res_load | (out_valid_q & ~out_ready_i);
  assign matched_d   = hit & ~empty & ~ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wild_q      <= wsm_pkg::WILD_RESET;
      case_q      <= wsm_pkg::CASE_RESET;
      loading_q   <= 1'b0;
      started_q   <= 1'b0;
      ovf_q       <= 1'b0;
      a0_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      wild_q      <= wild_d;
      case_q      <= case_d;
      loading_q   <= loading_d;
      started_q   <= started_d;
      ovf_q       <= ovf_d;
      a0_q        <= act_d[0];
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      matched_q  <= matched_d;
      mask_err_q <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign matched_o    = matched_q;
  assign mask_error_o = mask_err_q;

endmodule

[sv/wsm_checker.sv]
// ----------------------------------------------------------------------------
// wsm_checker: port-level checks for the wildcard string matcher
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module wsm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic req_type_i,
  input logic last_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic matched_o,
  input logic mask_error_o
);

  logic test_end;

  assign test_end = in_valid_i & in_ready_o & (req_type_i == wsm_pkg::REQ_TEST) & last_i;

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(matched_o) && $stable(mask_error_o))
    else $error("result changed while stalled");

  a_error_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(matched_o && mask_error_o))
    else $error("match reported with mask overflow");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    test_end |=> out_valid_o)
    else $error("no result after last test request");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(test_end))
    else $error("result without a last test request");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

endmodule

bind wildcard_string_match_core wsm_checker u_wsm_checker (.*);

[tb/match_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// match_checker: request and result monitor for the wildcard string matcher
// Watches both handshake channels and the register write port, keeps its own
// mask and per-position active flags, predicts a verdict for every closing
// test request and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module match_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           req_type_i,
  input  logic [wsm_pkg::CHAR_W-1:0]     char_value_i,
  input  logic                           last_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           matched_i,
  input  logic                           mask_error_i,
  input  logic                           cfg_we_i,
  input  logic [wsm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wsm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  import wsm_pkg::*;

  localparam int unsigned MLEN = MASK_LEN_DEFAULT;

  typedef struct packed {
    logic matched;
    logic mask_error;
  } verdict_t;

  logic [CHAR_W-1:0] mask_mem [MLEN];
  int unsigned       mask_len;
  logic              mask_ovf;
  logic              loading;
  logic              testing;
  logic [MLEN:0]     act;
  logic [CHAR_W-1:0] wild_reg;
  logic              case_exact;
  verdict_t          expected_verdicts [$];
  int unsigned       fails;

  function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] c);
    if (!case_exact && c >= 8'h61 && c <= 8'h7a) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic logic wild_at(input int unsigned i);
    return upcase(mask_mem[i]) == upcase(wild_reg);
  endfunction

  task automatic spread_wild();
    for (int unsigned i = 0; i < mask_len; i++) begin
      if (act[i] && wild_at(i)) begin
        act[i+1] = 1'b1;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fails++;
  endtask

  task automatic advance_matcher(input logic rq, input logic [CHAR_W-1:0] ch,
                                 input logic lst);
    logic [MLEN:0]     nxt;
    logic [CHAR_W-1:0] fc;
    verdict_t          v;
    if (rq == REQ_MASK) begin
      testing = 1'b0;
      if (!loading) begin
        mask_len = 0;
        mask_ovf = 1'b0;
        loading  = 1'b1;
      end
      if (ch != CHAR_NONE) begin
        if (mask_len < MLEN) begin
          mask_mem[mask_len] = ch;
          mask_len++;
        end else begin
          mask_ovf = 1'b1;
        end
      end
      if (lst) begin
        loading = 1'b0;
      end
    end else begin
      loading = 1'b0;
      if (!testing) begin
        act    = '0;
        act[0] = 1'b1;
        spread_wild();
        testing = 1'b1;
      end
      if (ch != CHAR_NONE) begin
        fc  = upcase(ch);
        nxt = '0;
        for (int unsigned i = 0; i < mask_len; i++) begin
          if (act[i]) begin
            if (wild_at(i)) begin
              nxt[i] = 1'b1;
            end else if (upcase(mask_mem[i]) == fc) begin
              nxt[i+1] = 1'b1;
            end
          end
        end
        act = nxt;
        spread_wild();
      end
      if (lst) begin
        testing      = 1'b0;
        v.matched    = !mask_ovf && mask_len > 0 && act[mask_len];
        v.mask_error = mask_ovf;
        expected_verdicts.push_back(v);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      mask_len   = 0;
      mask_ovf   = 1'b0;
      loading    = 1'b0;
      testing    = 1'b0;
      act        = '0;
      wild_reg   = WILD_RESET;
      case_exact = CASE_RESET;
      fails      = 0;
      expected_verdicts.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result with no test string pending");
        end else begin
          want = expected_verdicts.pop_front();
          if (matched_i !== want.matched) begin
            report_mismatch($sformatf("matched: got %b, expected %b",
                                      matched_i, want.matched));
          end
          if (mask_error_i !== want.mask_error) begin
            report_mismatch($sformatf("mask_error: got %b, expected %b",
                                      mask_error_i, want.mask_error));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_matcher(req_type_i, char_value_i, last_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WILDCARD: wild_reg = cfg_data_i;
          REG_CASE:     case_exact = cfg_data_i[0];
          default: ;
        endcase
      end
      fail_count_o <= fails;
      pending_o    <= expected_verdicts.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the wildcard string matcher
// Drives mask and test requests with random gaps and result back-pressure,
// steps through several wildcard and case settings between phases, and leaves
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import wsm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned PHASES       = 7;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic                  req_type   = REQ_MASK;
  logic [CHAR_W-1:0]     char_value = CHAR_NONE;
  logic                  last       = 1'b0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic                  matched;
  logic                  mask_error;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = REG_WILDCARD;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  int unsigned           fail_count;
  int unsigned           pending;

  int unsigned       sent = 0;
  logic              rush = 1'b0;
  logic [CHAR_W-1:0] wild_cfg = WILD_RESET;
  logic              case_cfg = CASE_RESET;
  logic [CHAR_W-1:0] mask_chars [$];

  wildcard_string_match_core DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .char_value_i (char_value),
    .last_i       (last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .matched_o    (matched),
    .mask_error_o (mask_error),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  match_checker CHK (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .req_type_i   (req_type),
    .char_value_i (char_value),
    .last_i       (last),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .matched_i    (matched),
    .mask_error_i (mask_error),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_req(input logic rq, input logic [CHAR_W-1:0] ch, input logic lst);
    int unsigned gap;
    gap = rush ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= rq;
    char_value <= ch;
    last       <= lst;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CHAR_W-1:0] wild, input logic exact);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_WILDCARD;
    cfg_data <= wild;
    @(posedge clk);
    cfg_idx  <= REG_CASE;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, exact};
    @(posedge clk);
    cfg_we   <= 1'b0;
    wild_cfg = wild;
    case_cfg = exact;
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return CHAR_NONE;
    if (r <= 4) return wild_cfg;
    if (r <= 12) begin
      case (r % 4)
        0: return 8'h61;
        1: return 8'h62;
        2: return 8'h41;
        default: return 8'h42;
      endcase
    end
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 23);
    if (r == 0) return 0;
    if (r == 1) return 64;
    if (r == 2) return $urandom_range(65, 70);
    if (r == 3) return $urandom_range(56, 63);
    return $urandom_range(1, 8);
  endfunction

  task automatic load_mask(input int unsigned len, input logic closed);
    logic [CHAR_W-1:0] c;
    mask_chars.delete();
    if (len == 0 && closed) begin
      send_req(REQ_MASK, CHAR_NONE, 1'b1);
    end
    for (int unsigned k = 0; k < len; k++) begin
      c = pick_char();
      if (c != CHAR_NONE) mask_chars.push_back(c);
      send_req(REQ_MASK, c, closed && k == len - 1);
    end
  endtask

  task automatic run_test(input logic mutate);
    logic [CHAR_W-1:0] txt [$];
    logic [CHAR_W-1:0] c;
    foreach (mask_chars[k]) begin
      c = mask_chars[k];
      if (c == wild_cfg) begin
        repeat ($urandom_range(0, 3)) txt.push_back(pick_char());
      end else begin
        if (!case_cfg && $urandom_range(0, 1) && (c | 8'h20) >= 8'h61 &&
            (c | 8'h20) <= 8'h7a) begin
          c = c ^ 8'h20;
        end
        txt.push_back(c);
      end
    end
    if (mutate) begin
      if (txt.size() > 0 && $urandom_range(0, 1)) begin
        txt[$urandom_range(0, txt.size() - 1)] = CHAR_W'($urandom_range(1, 255));
      end else begin
        txt.push_back(CHAR_W'($urandom_range(1, 255)));
      end
    end
    if (txt.size() == 0) begin
      send_req(REQ_TEST, CHAR_NONE, 1'b1);
    end else begin
      foreach (txt[k]) begin
        if ($urandom_range(0, 24) == 0) send_req(REQ_TEST, CHAR_NONE, 1'b0);
        send_req(REQ_TEST, txt[k], k == txt.size() - 1);
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    int unsigned calm;
    calm = 0;
    forever begin
      if (calm > 0) begin
        stall = 0;
        calm--;
      end else begin
        stall = $urandom_range(0, 10);
        if ($urandom_range(0, 7) == 0) calm = $urandom_range(10, 30);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [CHAR_W-1:0] phase_wild [PHASES];
    logic              phase_case [PHASES];
    int unsigned       base;
    int unsigned       kind;
    phase_wild = '{8'hFF, 8'h01, WILD_RESET, 8'h61, 8'h00, 8'h00, WILD_RESET};
    phase_case = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    phase_wild[5] = CHAR_W'($urandom_range(1, 255));
    phase_case[5] = 1'($urandom_range(0, 1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_cfg(WILD_RESET, CASE_RESET);

    // empty mask before any load, then a wildcard-only mask
    send_req(REQ_TEST, 8'h41, 1'b1);
    send_req(REQ_TEST, CHAR_NONE, 1'b1);
    send_req(REQ_MASK, WILD_RESET, 1'b1);
    send_req(REQ_TEST, CHAR_NONE, 1'b1);
    // extreme bytes, zero character in the mask, trailing wildcard
    send_req(REQ_MASK, 8'hFF, 1'b0);
    send_req(REQ_MASK, CHAR_NONE, 1'b0);
    send_req(REQ_MASK, 8'h61, 1'b0);
    send_req(REQ_MASK, WILD_RESET, 1'b1);
    send_req(REQ_TEST, 8'hFF, 1'b0);
    send_req(REQ_TEST, 8'h61, 1'b0);
    send_req(REQ_TEST, 8'h01, 1'b0);
    send_req(REQ_TEST, 8'h80, 1'b1);
    send_req(REQ_TEST, 8'hFF, 1'b0);
    send_req(REQ_TEST, 8'h41, 1'b1);
    // abandon a test with a new mask
    send_req(REQ_TEST, 8'h51, 1'b0);
    send_req(REQ_MASK, 8'h51, 1'b1);
    send_req(REQ_TEST, 8'h51, 1'b1);
    // cut a mask load short with a test
    send_req(REQ_MASK, 8'h5A, 1'b0);
    send_req(REQ_TEST, 8'h5A, 1'b1);
    // mask holding only a zero character
    send_req(REQ_MASK, CHAR_NONE, 1'b1);
    send_req(REQ_TEST, CHAR_NONE, 1'b1);

    base = sent;
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain();
      write_cfg(phase_wild[ph], phase_case[ph]);
      while (sent < base + (ph + 1) * RANDOM_ITEMS / PHASES) begin
        rush = ($urandom_range(0, 4) == 0);
        kind = $urandom_range(0, 19);
        if (kind <= 11) begin
          load_mask(pick_len(), 1'b1);
          repeat ($urandom_range(1, 3)) run_test($urandom_range(0, 3) == 0);
        end else if (kind <= 14) begin
          run_test($urandom_range(0, 1));
        end else if (kind <= 16) begin
          load_mask(pick_len(), 1'b0);
          run_test(1'b0);
        end else if (kind <= 18) begin
          repeat ($urandom_range(1, 4)) send_req(REQ_TEST, pick_char(), 1'b0);
          load_mask(pick_len(), 1'b1);
          run_test(1'b0);
        end else begin
          send_req(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)));
        end
      end
      rush = 1'b0;
      run_test(1'b0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
